/* rtl/apw_pkg.sv */
package apw_pkg;

	typedef logic [2:0] cfg_index_t;

	localparam cfg_index_t REG_FREQUENCY        = 3'd0;
	localparam cfg_index_t REG_WARP_WEIGHT      = 3'd1;
	localparam cfg_index_t REG_WARP_SCALE       = 3'd2;
	localparam cfg_index_t REG_SYMMETRY         = 3'd3;
	localparam cfg_index_t REG_VARIATION_WEIGHT = 3'd4;

	localparam int CORDIC_STEPS = 30;
	localparam int CX_W = 34;
	localparam int CZ_W = 35;

	localparam logic signed [CX_W-1:0] GAIN_Q30   = 34'sd652032874;
	localparam logic signed [CZ_W-1:0] PI_Q30     = 35'sd3373259426;
	localparam logic signed [CZ_W-1:0] HALFPI_Q30 = 35'sd1686629713;
	localparam logic signed [CZ_W-1:0] TWOPI_Q30  = 35'sd6746518852;

	localparam logic [63:0] TWOPI_Q60_FLOOR = 64'h6487ED5110B4611A;
	localparam logic [63:0] TWOPI_Q60_ROUND = 64'h6487ED5110B4611B;

	localparam logic [29:0] ATAN_Q30 [0:CORDIC_STEPS-1] = '{
		30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
		30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
		30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
		30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
		30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
		30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
	};

	// Two pi rounded to nearest with q fraction bits.
	function automatic logic [63:0] twopi_at(input int q);
		if (q >= 60) begin
			return TWOPI_Q60_ROUND;
		end
		return ((TWOPI_Q60_FLOOR >> (59 - q)) + 64'd1) >> 1;
	endfunction

endpackage

/* rtl/auger_point_warp_top.sv */
// Auger point warp: each word carries one point (x, y, z) in signed fixed point with
// FRAC_BITS fraction bits and yields one word (delta_x, delta_y, delta_z), in order.
// A new point is taken every cycle while no finished word is stalled at the output.
// Each point passes the phase reduction chain, one cell per product bit, then the
// 30-cell CORDIC chain and the four multiply stages behind them.
// The whole pipeline holds while a finished word is stalled at the output.
// Registers are written through cfg_write, cfg_index and cfg_data; the user must write
// them only while no point is in flight, as the block does not enforce this.
module auger_point_warp_top #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [DATA_WIDTH-1:0]   point_x,
	input  logic [DATA_WIDTH-1:0]   point_y,
	input  logic [DATA_WIDTH-1:0]   point_z,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DATA_WIDTH-1:0]   delta_x,
	output logic [DATA_WIDTH-1:0]   delta_y,
	output logic [DATA_WIDTH-1:0]   delta_z,
	input  logic                    cfg_write,
	input  apw_pkg::cfg_index_t     cfg_index,
	input  logic [DATA_WIDTH-1:0]   cfg_data
);

	localparam int W  = DATA_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int LS = 2 * W + 34;
	localparam int L  = LS + 14;
	localparam int DL = LS + 11;

	function automatic logic [W-1:0] sat_const(input logic signed [63:0] v);
		logic signed [63:0] vmax, vmin;
		vmax = (64'sd1 <<< (W - 1)) - 64'sd1;
		vmin = -vmax - 64'sd1;
		if (v > vmax) begin
			return vmax[W-1:0];
		end
		if (v < vmin) begin
			return vmin[W-1:0];
		end
		return v[W-1:0];
	endfunction

	function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
		logic [W:0] s;
		s = {a[W-1], a} + {b[W-1], b};
		if (s[W] != s[W-1]) begin
			return s[W] ? {1'b1, {(W - 1){1'b0}}} : {1'b0, {(W - 1){1'b1}}};
		end
		return s[W-1:0];
	endfunction

	localparam logic [W-1:0] RST_FREQ  = sat_const(64'sd5 <<< F);
	localparam logic [W-1:0] RST_WW    = sat_const(64'sd1 <<< (F - 1));
	localparam logic [W-1:0] RST_SCALE = sat_const(((64'sd1 <<< F) + 64'sd5) / 64'sd10);
	localparam logic [W-1:0] RST_VW    = sat_const(64'sd1 <<< F);

	logic [W-1:0] frequency_q, warp_weight_q, warp_scale_q, symmetry_q, variation_weight_q;
	logic [L-1:0] vld_q;
	logic en;

	logic [W-1:0] x_dl [1:DL];
	logic [W-1:0] y_dl [1:DL];
	logic [W-1:0] z_dl [1:DL];

	logic [W-1:0] sc_mag, sc_half, half_scale_q;
	logic [W-1:0] s_val, t_val, ax_q, ay_q;
	logic [W-1:0] a_x, b_x, a_y, b_y, sum_x_s1, sum_y_s1;
	logic [W-1:0] ox, oy, sym_ox, oy_s1, oy_s2, oy_s3;
	logic [W-1:0] e_x_s1, e_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frequency_q        <= RST_FREQ;
			warp_weight_q      <= RST_WW;
			warp_scale_q       <= RST_SCALE;
			symmetry_q         <= '0;
			variation_weight_q <= RST_VW;
		end else if (cfg_write) begin
			unique case (cfg_index)
				apw_pkg::REG_FREQUENCY:        frequency_q        <= cfg_data;
				apw_pkg::REG_WARP_WEIGHT:      warp_weight_q      <= cfg_data;
				apw_pkg::REG_WARP_SCALE:       warp_scale_q       <= cfg_data;
				apw_pkg::REG_SYMMETRY:         symmetry_q         <= cfg_data;
				apw_pkg::REG_VARIATION_WEIGHT: variation_weight_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en        = ~(vld_q[L-1] & out_stall);
	assign in_stall  = ~en;
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[L-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_dl[1] <= point_x;
			y_dl[1] <= point_y;
			z_dl[1] <= point_z;
			for (int k = 2; k <= DL; k++) begin
				x_dl[k] <= x_dl[k-1];
				y_dl[k] <= y_dl[k-1];
				z_dl[k] <= z_dl[k-1];
			end
		end
	end

	// Half the scale, rounded to nearest with ties away from zero.
	assign sc_mag  = warp_scale_q[W-1] ? (~warp_scale_q + W'(1)) : warp_scale_q;
	assign sc_half = W'(({1'b0, sc_mag} + (W+1)'(1)) >> 1);

	always_ff @(posedge clk) begin
		half_scale_q <= warp_scale_q[W-1] ? (~sc_half + W'(1)) : sc_half;
	end

	apw_sine #(.W(W), .F(F)) u_sin_x (
		.clk (clk), .en (en), .freq (frequency_q), .coord (point_x), .sin_out (s_val)
	);

	apw_sine #(.W(W), .F(F)) u_sin_y (
		.clk (clk), .en (en), .freq (frequency_q), .coord (point_y), .sin_out (t_val)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			ax_q <= sat_add(x_dl[LS-1][W-1] ? ~x_dl[LS-1] : x_dl[LS-1],
				x_dl[LS-1][W-1] ? W'(1) : W'(0));
			ay_q <= sat_add(y_dl[LS-1][W-1] ? ~y_dl[LS-1] : y_dl[LS-1],
				y_dl[LS-1][W-1] ? W'(1) : W'(0));
		end
	end

	apw_qmul #(.W(W), .F(F)) u_ax (
		.clk (clk), .en (en), .a (half_scale_q), .b (t_val), .q (a_x)
	);
	apw_qmul #(.W(W), .F(F)) u_bx (
		.clk (clk), .en (en), .a (ax_q), .b (t_val), .q (b_x)
	);
	apw_qmul #(.W(W), .F(F)) u_ay (
		.clk (clk), .en (en), .a (half_scale_q), .b (s_val), .q (a_y)
	);
	apw_qmul #(.W(W), .F(F)) u_by (
		.clk (clk), .en (en), .a (ay_q), .b (s_val), .q (b_y)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_x_s1 <= sat_add(a_x, b_x);
			sum_y_s1 <= sat_add(a_y, b_y);
		end
	end

	apw_qmul #(.W(W), .F(F)) u_ox (
		.clk (clk), .en (en), .a (warp_weight_q), .b (sum_x_s1), .q (ox)
	);
	apw_qmul #(.W(W), .F(F)) u_oy (
		.clk (clk), .en (en), .a (warp_weight_q), .b (sum_y_s1), .q (oy)
	);
	apw_qmul #(.W(W), .F(F)) u_sym (
		.clk (clk), .en (en), .a (symmetry_q), .b (ox), .q (sym_ox)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			oy_s1  <= oy;
			oy_s2  <= oy_s1;
			oy_s3  <= oy_s2;
			e_x_s1 <= sat_add(x_dl[LS+10], sym_ox);
			e_y_s1 <= sat_add(y_dl[LS+10], oy_s3);
		end
	end

	apw_qmul #(.W(W), .F(F)) u_dx (
		.clk (clk), .en (en), .a (variation_weight_q), .b (e_x_s1), .q (delta_x)
	);
	apw_qmul #(.W(W), .F(F)) u_dy (
		.clk (clk), .en (en), .a (variation_weight_q), .b (e_y_s1), .q (delta_y)
	);
	apw_qmul #(.W(W), .F(F)) u_dz (
		.clk (clk), .en (en), .a (variation_weight_q), .b (z_dl[DL]), .q (delta_z)
	);

endmodule

/* rtl/apw_mulmag.sv */
module apw_mulmag #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic           en,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] prod,
	output logic           neg
);

	localparam int H = (W + 1) / 2;
	localparam int PW = 4 * H;

	logic [W-1:0] a_mag, b_mag;
	logic [H-1:0] a_lo, a_hi, b_lo, b_hi;
	logic [2*H-1:0] pll_s1, plh_s1, phl_s1, phh_s1;
	logic neg_s1, neg_s2;
	logic [PW-1:0] sum;
	logic [2*W-1:0] prod_s2;

	assign a_mag = a[W-1] ? (~a + W'(1)) : a;
	assign b_mag = b[W-1] ? (~b + W'(1)) : b;
	assign a_lo = a_mag[H-1:0];
	assign b_lo = b_mag[H-1:0];
	assign a_hi = H'(a_mag >> H);
	assign b_hi = H'(b_mag >> H);

	always_ff @(posedge clk) begin
		if (en) begin
			pll_s1 <= a_lo * b_lo;
			plh_s1 <= a_lo * b_hi;
			phl_s1 <= a_hi * b_lo;
			phh_s1 <= a_hi * b_hi;
			neg_s1 <= a[W-1] ^ b[W-1];
		end
	end

	assign sum = PW'(pll_s1) + ((PW'(plh_s1) + PW'(phl_s1)) << H) + (PW'(phh_s1) << (2 * H));

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= sum[2*W-1:0];
			neg_s2  <= neg_s1;
		end
	end

	assign prod = prod_s2;
	assign neg  = neg_s2;

endmodule

/* rtl/apw_qmul.sv */
module apw_qmul #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] q
);

	localparam int RW = 2 * W + 1;
	localparam logic [RW-1:0] VMAX = (RW'(1) << (W - 1)) - RW'(1);

	logic [2*W-1:0] prod;
	logic neg;
	logic [RW-1:0] rnd, shf, limit, mag_c;
	logic [W-1:0] mag_w, q_s3;

	apw_mulmag #(.W(W)) u_mul (
		.clk  (clk),
		.en   (en),
		.a    (a),
		.b    (b),
		.prod (prod),
		.neg  (neg)
	);

	assign rnd   = {1'b0, prod} + (RW'(1) << (F - 1));
	assign shf   = rnd >> F;
	assign limit = VMAX + RW'(neg);
	assign mag_c = (shf > limit) ? limit : shf;
	assign mag_w = mag_c[W-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			q_s3 <= neg ? (~mag_w + W'(1)) : mag_w;
		end
	end

	assign q = q_s3;

endmodule

/* rtl/apw_mod_cell.sv */
module apw_mod_cell #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*F+2:0]      rem_i,
	input  logic [2*W-1:0]      bits_i,
	input  logic                neg_i,
	output logic [2*F+2:0]      rem_o,
	output logic [2*W-1:0]      bits_o,
	output logic                neg_o
);

	localparam int RW = 2 * F + 3;
	localparam logic [RW:0] TWOPI = (RW+1)'(apw_pkg::twopi_at(2 * F));

	logic [RW:0] cat, nxt;
	logic [RW-1:0] rem_s1;
	logic [2*W-1:0] bits_s1;
	logic neg_s1;

	assign cat = {rem_i, bits_i[2*W-1]};
	assign nxt = (cat >= TWOPI) ? (cat - TWOPI) : cat;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= nxt[RW-1:0];
			bits_s1 <= bits_i << 1;
			neg_s1  <= neg_i;
		end
	end

	assign rem_o  = rem_s1;
	assign bits_o = bits_s1;
	assign neg_o  = neg_s1;

endmodule

/* rtl/apw_cordic_cell.sv */
module apw_cordic_cell #(
	parameter int STEP = 0
) (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [apw_pkg::CX_W-1:0]   x_i,
	input  logic signed [apw_pkg::CX_W-1:0]   y_i,
	input  logic signed [apw_pkg::CZ_W-1:0]   z_i,
	input  logic                               neg_i,
	output logic signed [apw_pkg::CX_W-1:0]   x_o,
	output logic signed [apw_pkg::CX_W-1:0]   y_o,
	output logic signed [apw_pkg::CZ_W-1:0]   z_o,
	output logic                               neg_o
);

	localparam logic signed [apw_pkg::CZ_W-1:0] ANGLE =
		$signed({5'b0, apw_pkg::ATAN_Q30[STEP]});

	logic signed [apw_pkg::CX_W-1:0] xs, ys, x_s1, y_s1;
	logic signed [apw_pkg::CZ_W-1:0] z_s1;
	logic neg_s1;

	assign xs = x_i >>> STEP;
	assign ys = y_i >>> STEP;

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_i[apw_pkg::CZ_W-1]) begin
				x_s1 <= x_i - ys;
				y_s1 <= y_i + xs;
				z_s1 <= z_i - ANGLE;
			end else begin
				x_s1 <= x_i + ys;
				y_s1 <= y_i - xs;
				z_s1 <= z_i + ANGLE;
			end
			neg_s1 <= neg_i;
		end
	end

	assign x_o   = x_s1;
	assign y_o   = y_s1;
	assign z_o   = z_s1;
	assign neg_o = neg_s1;

endmodule

/* rtl/apw_sine.sv */
module apw_sine #(
	parameter int W = 32,
	parameter int F = 16
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] freq,
	input  logic [W-1:0] coord,
	output logic [W-1:0] sin_out
);

	localparam int RW = 2 * F + 3;
	localparam int NC = 2 * W;
	localparam int NS = apw_pkg::CORDIC_STEPS;
	localparam int XW = apw_pkg::CX_W;
	localparam int ZW = apw_pkg::CZ_W;
	localparam int SW = RW + 30;
	localparam logic signed [63:0] VMAX64 = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [63:0] VMIN64 = -VMAX64 - 64'sd1;

	logic [2*W-1:0] prod;
	logic neg;

	logic [RW-1:0]  rem_c  [0:NC];
	logic [2*W-1:0] bits_c [0:NC];
	logic           neg_c  [0:NC];

	logic signed [XW-1:0] cx [0:NS];
	logic signed [XW-1:0] cy [0:NS];
	logic signed [ZW-1:0] cz [0:NS];
	logic                 cn [0:NS];

	logic [SW-1:0] zw;
	logic signed [ZW-1:0] z0, z1, z2, fold_z_s1;
	logic fold_neg_s1;
	logic signed [63:0] ye, rr, sv;
	logic [W-1:0] sin_s1;

	apw_mulmag #(.W(W)) u_mul (
		.clk  (clk),
		.en   (en),
		.a    (freq),
		.b    (coord),
		.prod (prod),
		.neg  (neg)
	);

	assign rem_c[0]  = '0;
	assign bits_c[0] = prod;
	assign neg_c[0]  = neg;

	for (genvar k = 0; k < NC; k++) begin : g_mod
		apw_mod_cell #(.W(W), .F(F)) u_cell (
			.clk    (clk),
			.en     (en),
			.rem_i  (rem_c[k]),
			.bits_i (bits_c[k]),
			.neg_i  (neg_c[k]),
			.rem_o  (rem_c[k+1]),
			.bits_o (bits_c[k+1]),
			.neg_o  (neg_c[k+1])
		);
	end

	assign zw = ({rem_c[NC], 30'b0}) >> (2 * F);
	assign z0 = $signed({2'b0, zw[32:0]});
	assign z1 = (z0 > apw_pkg::PI_Q30) ? (z0 - apw_pkg::TWOPI_Q30) : z0;

	always_comb begin
		if (z1 > apw_pkg::HALFPI_Q30) begin
			z2 = apw_pkg::PI_Q30 - z1;
		end else if (z1 < -apw_pkg::HALFPI_Q30) begin
			z2 = -apw_pkg::PI_Q30 - z1;
		end else begin
			z2 = z1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fold_z_s1   <= z2;
			fold_neg_s1 <= neg_c[NC];
		end
	end

	assign cx[0] = apw_pkg::GAIN_Q30;
	assign cy[0] = '0;
	assign cz[0] = fold_z_s1;
	assign cn[0] = fold_neg_s1;

	for (genvar i = 0; i < NS; i++) begin : g_cordic
		apw_cordic_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.en    (en),
			.x_i   (cx[i]),
			.y_i   (cy[i]),
			.z_i   (cz[i]),
			.neg_i (cn[i]),
			.x_o   (cx[i+1]),
			.y_o   (cy[i+1]),
			.z_o   (cz[i+1]),
			.neg_o (cn[i+1])
		);
	end

	assign ye = {{(64 - XW){cy[NS][XW-1]}}, cy[NS]};

	if (F < 30) begin : g_round
		assign rr = (ye + (64'sd1 <<< (29 - F))) >>> (30 - F);
	end else begin : g_plain
		assign rr = ye;
	end

	assign sv = cn[NS] ? -rr : rr;

	always_ff @(posedge clk) begin
		if (en) begin
			if (sv > VMAX64) begin
				sin_s1 <= VMAX64[W-1:0];
			end else if (sv < VMIN64) begin
				sin_s1 <= VMIN64[W-1:0];
			end else begin
				sin_s1 <= sv[W-1:0];
			end
		end
	end

	assign sin_out = sin_s1;

endmodule
